// ----- rtl/sst_pkg.sv -----
// shared types and constants for the single-server fifo queue timer
package sst_pkg;

    // default number of waiting slots in the queue store
    localparam int QUEUE_DEPTH_DEF = 16;

    // event codes carried on the result channel
    typedef enum logic [1:0] {
        EV_ENTER   = 2'd0,
        EV_DEPART  = 2'd1,
        EV_BEGIN   = 2'd2,
        EV_REFUSE  = 2'd3
    } t_event_kind;

    // commands from controller to datapath
    typedef struct packed {
        logic load;      // input transfer: latch item, plan events, advance clock
        logic emit_arr;  // put arrival (enter or refuse) into the result register
        logic emit_dep;  // put departure into the result register
        logic emit_beg;  // put begin service into the result register
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic now_arr;   // offered item carries an arrival
        logic now_dep;   // offered item would see a departure
        logic now_beg;   // offered item would see a service start
        logic held_dep;  // planned departure for the tick in progress
        logic held_beg;  // planned service start for the tick in progress
        logic out_free;  // result register can take a new result
        logic busy;      // server occupied
        logic q_empty;   // no packet waiting
    } t_sts;

endpackage

// ----- rtl/sst_ifs.sv -----
// valid/ready channel interfaces for input items and result items

interface sst_in_if;
    logic        valid;
    logic        ready;
    logic        arrives;
    logic [15:0] packet_id;
    logic [15:0] service_ticks;

    modport source (output valid, arrives, packet_id, service_ticks, input ready);
    modport sink   (input valid, arrives, packet_id, service_ticks, output ready);
endinterface

interface sst_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  event_kind;
    logic [15:0] event_packet;
    logic [31:0] event_time;
    logic [31:0] queue_wait;
    logic [31:0] system_time;
    logic        last_event;

    modport source (output valid, event_kind, event_packet, event_time, queue_wait,
                    system_time, last_event, input ready);
    modport sink   (input valid, event_kind, event_packet, event_time, queue_wait,
                    system_time, last_event, output ready);
endinterface

// ----- rtl/sst_ctrl.sv -----
// controller state machine: walks the events of one tick in order
module sst_ctrl import sst_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ARR,
        S_DEP,
        S_RD,
        S_BEG
    } t_state;

    t_state r_state, n_state;

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_sts.now_arr)
                        n_state = S_ARR;
                    else if (i_sts.now_dep)
                        n_state = S_DEP;
                    else if (i_sts.now_beg)
                        n_state = S_RD;
                end
            end
            S_ARR: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_arr = 1'b1;
                    if (i_sts.held_dep)
                        n_state = S_DEP;
                    else if (i_sts.held_beg)
                        n_state = S_RD;
                    else
                        n_state = S_IDLE;
                end
            end
            S_DEP: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_dep = 1'b1;
                    n_state = i_sts.held_beg ? S_RD : S_IDLE;
                end
            end
            // wait state for the registered store read of the queue head
            S_RD: begin
                n_state = S_BEG;
            end
            S_BEG: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_beg = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- rtl/sst_dp.sv -----
// datapath: tick clock, queue store and pointers, server state, result register
module sst_dp import sst_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_arrives,
    input  logic [15:0] i_packet_id,
    input  logic [15:0] i_service_ticks,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    sst_out_if.source   o_res
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    // queue store: service time, arrival time, id
    logic [63:0] r_mem [QUEUE_DEPTH];
    logic [63:0] r_rd_data;

    // control state
    logic [31:0]   r_tick;
    logic [AW-1:0] r_head;
    logic [AW-1:0] r_tail;
    logic [CW-1:0] r_count;
    logic          r_busy;
    logic [31:0]   r_end;
    logic [15:0]   r_serv_id;
    logic [31:0]   r_serv_arr;
    logic          r_enter;
    logic          r_dep;
    logic          r_beg;
    logic          r_valid;

    // latched item of the tick in progress
    logic [15:0] r_id;
    logic [15:0] r_svc;
    logic [31:0] r_now;

    // result payload
    logic [1:0]  r_kind;
    logic [15:0] r_packet;
    logic [31:0] r_time;
    logic [31:0] r_wait;
    logic [31:0] r_sys;
    logic        r_last;

    logic          full;
    logic          f_enter;
    logic          f_dep;
    logic          f_beg;
    logic          out_free;
    logic [AW-1:0] tail_nxt;
    logic [AW-1:0] head_nxt;
    logic [15:0]   rd_id;
    logic [31:0]   rd_arr;
    logic [15:0]   rd_svc;

    // event plan for the offered item
    always_comb begin
        full     = (r_count == CW'(QUEUE_DEPTH));
        f_enter  = i_arrives && !full;
        f_dep    = r_busy && (r_tick == r_end);
        f_beg    = (!r_busy || f_dep) && ((r_count != '0) || f_enter);
        out_free = !r_valid || o_res.ready;
        tail_nxt = (r_tail == AW'(QUEUE_DEPTH - 1)) ? '0 : r_tail + 1'b1;
        head_nxt = (r_head == AW'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
        rd_id    = r_rd_data[15:0];
        rd_arr   = r_rd_data[47:16];
        rd_svc   = r_rd_data[63:48];
    end

    // status
    always_comb begin
        o_sts.now_arr  = i_arrives;
        o_sts.now_dep  = f_dep;
        o_sts.now_beg  = f_beg;
        o_sts.held_dep = r_dep;
        o_sts.held_beg = r_beg;
        o_sts.out_free = out_free;
        o_sts.busy     = r_busy;
        o_sts.q_empty  = (r_count == '0);
    end

    // queue store write on entry
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_arr && r_enter) begin
            r_mem[r_tail] <= {r_svc, r_now, r_id};
        end
    end

    // registered read of the queue head
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[r_head];
    end

    // control state updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick     <= '0;
            r_head     <= '0;
            r_tail     <= '0;
            r_count    <= '0;
            r_busy     <= 1'b0;
            r_end      <= '0;
            r_serv_id  <= '0;
            r_serv_arr <= '0;
            r_enter    <= 1'b0;
            r_dep      <= 1'b0;
            r_beg      <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_tick  <= r_tick + 32'd1;
                r_enter <= f_enter;
                r_dep   <= f_dep;
                r_beg   <= f_beg;
            end
            if (i_cmd.emit_arr && r_enter) begin
                r_tail  <= tail_nxt;
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.emit_dep) begin
                r_busy <= 1'b0;
            end
            if (i_cmd.emit_beg) begin
                r_head     <= head_nxt;
                r_count    <= r_count - 1'b1;
                r_busy     <= 1'b1;
                r_end      <= r_now + {16'd0, rd_svc};
                r_serv_id  <= rd_id;
                r_serv_arr <= rd_arr;
            end
            // result register holds until transfer
            if (i_cmd.emit_arr || i_cmd.emit_dep || i_cmd.emit_beg)
                r_valid <= 1'b1;
            else if (o_res.ready)
                r_valid <= 1'b0;
        end
    end

    // item latch, zero service time raised to one tick
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_id  <= i_packet_id;
            r_svc <= (i_service_ticks == '0) ? 16'd1 : i_service_ticks;
            r_now <= r_tick;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_arr) begin
            r_kind   <= r_enter ? EV_ENTER : EV_REFUSE;
            r_packet <= r_id;
            r_time   <= r_now;
            r_wait   <= '0;
            r_sys    <= '0;
            r_last   <= !r_dep && !r_beg;
        end else if (i_cmd.emit_dep) begin
            r_kind   <= EV_DEPART;
            r_packet <= r_serv_id;
            r_time   <= r_now;
            r_wait   <= '0;
            r_sys    <= r_end - r_serv_arr;
            r_last   <= !r_beg;
        end else if (i_cmd.emit_beg) begin
            r_kind   <= EV_BEGIN;
            r_packet <= rd_id;
            r_time   <= r_now;
            r_wait   <= r_now - rd_arr;
            r_sys    <= '0;
            r_last   <= 1'b1;
        end
    end

    assign o_res.valid        = r_valid;
    assign o_res.event_kind   = r_kind;
    assign o_res.event_packet = r_packet;
    assign o_res.event_time   = r_time;
    assign o_res.queue_wait   = r_wait;
    assign o_res.system_time  = r_sys;
    assign o_res.last_event   = r_last;

endmodule

// ----- rtl/single_server_fifo_queue_timer.sv -----
// single-server fifo queue timer: one input item per tick, up to three results per tick
// a tick with no events stays in idle; otherwise each result has its own state, and a
// service start first waits a state for the registered queue-store read; a new item is
// taken only in idle; results stall the tick in progress when the sink holds ready low
// reset clears the tick clock, queue pointers and count, server state and result valid
// the queue store is not cleared: only entries counted in the queue are ever read
module single_server_fifo_queue_timer import sst_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sst_in_if.sink    i_item,
    sst_out_if.source o_res
);

    t_cmd s_cmd;
    t_sts s_sts;

    // controller
    sst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (i_item.ready),
        .i_sts      (s_sts),
        .o_cmd      (s_cmd)
    );

    // datapath
    sst_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_arrives       (i_item.arrives),
        .i_packet_id     (i_item.packet_id),
        .i_service_ticks (i_item.service_ticks),
        .i_cmd           (s_cmd),
        .o_sts           (s_sts),
        .o_res           (o_res)
    );

    // at most one command per cycle
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({s_cmd.load, s_cmd.emit_arr, s_cmd.emit_dep, s_cmd.emit_beg}))
        else $error("more than one controller command in a cycle");

    // departure only from a busy server
    a_dep_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.emit_dep |-> s_sts.busy)
        else $error("departure with idle server");

    // service start only on an idle server with a waiting packet
    a_beg_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.emit_beg |-> (!s_sts.busy && !s_sts.q_empty))
        else $error("service start on busy server or empty queue");

    // begin service is always the final result of its tick
    a_beg_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.event_kind == EV_BEGIN)) |-> o_res.last_event)
        else $error("begin service not marked last");

endmodule
